// File: design/hpc_pkg.sv
// Package with shared types, constants and conversion functions of the half precision converter.
package hpc_pkg;

  typedef enum logic {
    OP_TO_HALF   = 1'b0,
    OP_FROM_HALF = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] operand_bits;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_bits;
  } out_beat_t;

  localparam logic [15:0] HALF_INF    = 16'h7c00;
  localparam logic [31:0] SINGLE_INF  = 32'h7f800000;

  // Binary32 to binary16: rebias, truncate the fraction, flush or saturate.
  function automatic logic [31:0] narrow_to_half(input logic [31:0] x);
    logic        sgn;
    logic [7:0]  e8;
    logic [31:0] res;
    begin
      sgn = x[31];
      e8  = x[30:23];
      res = '0;
      res[15] = sgn;
      if (e8 <= 8'd112) begin
        res[14:0] = '0;
      end else if (e8 >= 8'd143) begin
        res[14:0] = HALF_INF[14:0];
      end else begin
        res[14:10] = 5'(e8 - 8'd112);
        res[9:0]   = x[22:13];
      end
      narrow_to_half = res;
    end
  endfunction

  // Binary16 to binary32, normalising subnormals with a leading-zero count.
  function automatic logic [31:0] widen_from_half(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [10:0] sh;
    logic [31:0] res;
    begin
      e   = h[14:10];
      m   = h[9:0];
      k   = 4'd10;
      for (int i = 0; i < 10; i++) begin
        if (m[i]) k = 4'(10 - i);
      end
      sh  = 11'({1'b0, m} << k);
      res = '0;
      res[31] = h[15];
      if (e == 5'd0) begin
        if (m != 10'd0) begin
          res[30:23] = 8'd113 - 8'(k);
          res[22:13] = sh[9:0];
        end
      end else if (e == 5'd31) begin
        res[30:0]  = SINGLE_INF[30:0];
        res[22:13] = m;
      end else begin
        res[30:23] = 8'(e) + 8'd112;
        res[22:13] = m;
      end
      widen_from_half = res;
    end
  endfunction

endpackage

// File: design/hpc_if.sv
// Valid/ready channel interface carrying one payload beat.
interface hpc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/hpc_core.sv
// Combinational conversion core selecting the direction by op.
module hpc_core (
  input  hpc_pkg::in_beat_t  din,
  output hpc_pkg::out_beat_t dout
);
  import hpc_pkg::*;

  always_comb begin
    unique case (din.op)
      OP_TO_HALF:   dout.result_bits = narrow_to_half(din.operand_bits);
      OP_FROM_HALF: dout.result_bits = widen_from_half(din.operand_bits[15:0]);
      default:      dout.result_bits = '0;
    endcase
  end
endmodule

// File: design/half_precision_converter.sv
// Top level of the half precision converter: input register, conversion core, result register.
// Converts between IEEE 754 binary32 and binary16 bit patterns, one beat in and one beat out.
// op 0 narrows binary32 to binary16 by truncation, flushing small values to signed zero and
// large values, infinities and NaNs to signed infinity; op 1 widens binary16 exactly. A beat
// passes through the input register and then the result register, with the conversion logic
// between them. Both registers advance together whenever the result register is free or
// being taken, so while the output does not stall a new beat is accepted every cycle and
// throughput is one beat per clock; a stall at the output holds both stages.
module half_precision_converter (
  input logic clk,
  input logic rst_n,
  hpc_if.sink   in_ch,
  hpc_if.source out_ch
);
  import hpc_pkg::*;

  logic      s1_vld_r, s1_vld_nxt;
  logic      s2_vld_r, s2_vld_nxt;
  in_beat_t  s1_r;
  out_beat_t s2_r, conv;
  logic      adv;

  // The pipeline moves when the result stage is empty or being drained.
  assign adv          = !s2_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = s2_vld_r;
  assign out_ch.data  = s2_r;

  hpc_core u_core (.din(s1_r), .dout(conv));

  always_comb begin
    s1_vld_nxt = adv ? in_ch.valid : s1_vld_r;
    s2_vld_nxt = adv ? s1_vld_r : s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_ch.data;
      s2_r <= conv;
    end
  end
endmodule

// File: test/half_precision_converter_tb.sv
// Testbench for the half precision converter: directed and random conversions checked in order.
module half_precision_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  logic clk;
  logic rst_n;
  bit   failed;
  int   beats_sent;

  hpc_if #(.payload_t(in_beat_t))  in_ch ();
  hpc_if #(.payload_t(out_beat_t)) out_ch ();

  half_precision_converter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Expected converted words, oldest first.
  logic [31:0] expected_words[$];

  // The 20 ns clock runs for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Narrowing: rebias 127 to 15, truncate the fraction, flush to zero or saturate to infinity.
  function automatic logic [31:0] half_of_single(input logic [31:0] x);
    int          rebiased;
    logic [31:0] word;
    rebiased = int'(x[30:23]) - 112;
    word = '0;
    word[15] = x[31];
    if (rebiased >= 31) begin
      word[14:10] = 5'h1f;
    end else if (rebiased > 0) begin
      word[14:10] = rebiased[4:0];
      word[9:0]   = x[22:13];
    end
    return word;
  endfunction

  // Widening is exact; a subnormal is shifted until its leading one reaches bit 10.
  function automatic logic [31:0] single_of_half(input logic [15:0] h);
    logic [31:0] word;
    logic [10:0] frac;
    logic [7:0]  expo;
    word = '0;
    word[31] = h[15];
    frac = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (frac != '0) begin
        expo = 8'd113;
        while (!frac[10]) begin
          frac = frac << 1;
          expo = expo - 8'd1;
        end
        word[30:23] = expo;
        word[22:13] = frac[9:0];
      end
    end else if (h[14:10] == 5'h1f) begin
      word[30:23] = 8'hff;
      word[22:13] = h[9:0];
    end else begin
      word[30:23] = 8'(h[14:10]) + 8'd112;
      word[22:13] = h[9:0];
    end
    return word;
  endfunction

  // Sends one beat after a random gap; the expectation is queued at acceptance.
  // The task returns at the accepting edge, so valid stays high into the next beat
  // when there is no gap.
  task automatic send_beat(input op_t op, input logic [31:0] operand);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  <= '{op: op, operand_bits: operand};
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(op == OP_TO_HALF ? half_of_single(operand)
                                              : single_of_half(operand[15:0]));
    beats_sent++;
  endtask

  // Random stall before each result beat, with stall-free stretches.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result_bits: unexpected beat, actual %h", out_ch.data.result_bits);
        failed = 1'b1;
      end else begin
        logic [31:0] want;
        want = expected_words.pop_front();
        if (out_ch.data.result_bits !== want) begin
          $error("result_bits: expected %h actual %h", want, out_ch.data.result_bits);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Narrowing edges: zero, flush limits, largest finite, overflow, infinity, NaN.
  task automatic test_narrowing_edges();
    logic [31:0] words[$];
    words = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3800_0000, 32'h3880_0000,
              32'hb880_0000, 32'h477f_e000, 32'h477f_ffff, 32'h4780_0000, 32'h7f80_0000,
              32'hff80_0000, 32'h7fc0_0001, 32'hffff_ffff};
    foreach (words[i]) send_beat(OP_TO_HALF, words[i]);
  endtask

  // Widening edges: zeros, smallest and largest subnormal, normals, infinity, NaN, upper bits.
  task automatic test_widening_edges();
    logic [31:0] words[$];
    words = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_83ff, 32'h0000_0200,
              32'h0000_0400, 32'h0000_7bff, 32'h0000_7c00, 32'h0000_fc00, 32'h0000_7e01,
              32'hffff_3c00, 32'habcd_ffff};
    foreach (words[i]) send_beat(OP_FROM_HALF, words[i]);
  endtask

  // Random words, biased towards exponents near the interesting boundaries.
  task automatic test_random_words(input int count);
    logic [31:0] operand;
    op_t         op;
    for (int n = 0; n < count; n++) begin
      operand = $urandom();
      op = op_t'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        if (op == OP_TO_HALF) operand[30:23] = 8'($urandom_range(108, 147));
        else operand[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'h1f;
      end
      send_beat(op, operand);
      // Once midway, hold off until the pipe is empty.
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_narrowing_edges();
    test_widening_edges();
    test_random_words(550);
    wait_drained();
    repeat (10) @(negedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Generous cap on the run time.
  initial begin
    #(20ns * 200000);
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: filelist.f
design/hpc_pkg.sv
design/hpc_if.sv
design/hpc_core.sv
design/half_precision_converter.sv
test/half_precision_converter_tb.sv
